// ===== sv/jsq_pkg.sv =====
package jsq_pkg;

    // Queue storage geometry (depth must stay a power of two for pointer wrap)
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int GAP_W   = 24;
    localparam int SVC_W   = 24;
    localparam int TIME_W  = 48;
    localparam int CAP_W   = 5;
    localparam int LEN_W   = 5;
    localparam int DROP_W  = 32;
    localparam int WAIT_W  = 56;
    localparam int LSUM_W  = 40;
    localparam int PLACE_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

    // Placement codes
    localparam logic [PLACE_W-1:0] PLACE_Q0   = 2'd0;
    localparam logic [PLACE_W-1:0] PLACE_Q1   = 2'd1;
    localparam logic [PLACE_W-1:0] PLACE_DROP = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic arrive;
        logic serve;
        logic sojourn;
        logic acc0;
        logic acc1;
        logic load_out;
    } cmd_t;

endpackage

// ===== sv/jsq_job_if.sv =====
interface jsq_job_if;
    logic                      valid;
    logic                      ready;
    logic [jsq_pkg::GAP_W-1:0] interval_time;
    logic [jsq_pkg::SVC_W-1:0] service_time;
    logic                      start_run;
    logic                      first_to_q1;

    modport source (
        output valid, interval_time, service_time, start_run, first_to_q1,
        input  ready
    );
    modport sink (
        input  valid, interval_time, service_time, start_run, first_to_q1,
        output ready
    );
endinterface

// ===== sv/jsq_cfg_if.sv =====
interface jsq_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [jsq_pkg::CAP_W-1:0] capacity_limit;

    modport source (
        output valid, capacity_limit,
        input  ready
    );
    modport sink (
        input  valid, capacity_limit,
        output ready
    );
endinterface

// ===== sv/jsq_result_if.sv =====
interface jsq_result_if;
    logic                        valid;
    logic                        ready;
    logic [jsq_pkg::PLACE_W-1:0] placement;
    logic [jsq_pkg::LEN_W-1:0]   q0_length;
    logic [jsq_pkg::LEN_W-1:0]   q1_length;
    logic [jsq_pkg::DROP_W-1:0]  dropped_count;
    logic [jsq_pkg::WAIT_W-1:0]  wait_total;
    logic [jsq_pkg::LSUM_W-1:0]  q0_length_sum;
    logic [jsq_pkg::LSUM_W-1:0]  q1_length_sum;

    modport source (
        output valid, placement, q0_length, q1_length, dropped_count,
               wait_total, q0_length_sum, q1_length_sum,
        input  ready
    );
    modport sink (
        input  valid, placement, q0_length, q1_length, dropped_count,
               wait_total, q0_length_sum, q1_length_sum,
        output ready
    );
endinterface

// ===== sv/two_queue_shortest_dispatch.sv =====
// Channel   Dir  Handshake      Payload
// jobs      in   valid/ready    interval_time, service_time, start_run, first_to_q1
// cfg       in   valid/ready    capacity_limit (ready always high)
// results   out  valid/ready    placement, queue lengths, drop count, wait and length sums
//
// Each request steps through the states in order: IDLE accepts and places the job, SERVE
// serves the queue heads, SOJOURN forms the sojourns, ACCUM0 and ACCUM1 run the shared
// 57-bit wait adder and RESULT loads the output register. No new job is taken until IDLE.
// Reset is asynchronous: queues empty, clock and sums zero, capacity 10.
// A result held at the output stalls only the next output load; a new job is
// accepted while it waits.
module two_queue_shortest_dispatch (
    input  logic         clk,
    input  logic         rst_n,
    jsq_job_if.sink      jobs,
    jsq_cfg_if.sink      cfg,
    jsq_result_if.source results
);

    jsq_pkg::cmd_t cmd;

    assign cfg.ready = 1'b1;

    jsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (jobs.valid),
        .job_ready (jobs.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd)
    );

    jsq_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg_we            (cfg.valid),
        .cfg_capacity      (cfg.capacity_limit),
        .job_interval_time (jobs.interval_time),
        .job_service_time  (jobs.service_time),
        .job_start_run     (jobs.start_run),
        .job_first_to_q1   (jobs.first_to_q1),
        .placement         (results.placement),
        .q0_length         (results.q0_length),
        .q1_length         (results.q1_length),
        .dropped_count     (results.dropped_count),
        .wait_total        (results.wait_total),
        .q0_length_sum     (results.q0_length_sum),
        .q1_length_sum     (results.q1_length_sum)
    );

`ifndef SYNTHESIS
    // One job in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        jobs.valid && jobs.ready |=> !jobs.ready)
        else $error("job accepted while another is in flight");

    // Reported lengths never exceed the queue depth
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (32'(results.q0_length) <= 32'(jsq_pkg::QUEUE_DEPTH)) &&
                          (32'(results.q1_length) <= 32'(jsq_pkg::QUEUE_DEPTH)))
        else $error("queue length above depth");

    // A new result appears only at the end of processing, never from idle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(!jobs.ready))
        else $error("result loaded while idle");
`endif

endmodule

// ===== sv/jsq_ctrl.sv =====
module jsq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output jsq_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SERVE   = 6'b000010,
        ST_SOJOURN = 6'b000100,
        ST_ACCUM0  = 6'b001000,
        ST_ACCUM1  = 6'b010000,
        ST_RESULT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign job_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Sequence one request through place, serve, sojourn, sum and load
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    cmd.arrive = 1'b1;
                    state_next = ST_SERVE;
                end
            end
            ST_SERVE:
            begin
                cmd.serve  = 1'b1;
                state_next = ST_SOJOURN;
            end
            ST_SOJOURN:
            begin
                cmd.sojourn = 1'b1;
                state_next  = ST_ACCUM0;
            end
            ST_ACCUM0:
            begin
                cmd.acc0   = 1'b1;
                state_next = ST_ACCUM1;
            end
            ST_ACCUM1:
            begin
                cmd.acc1   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                // Hold until the output register is free
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/jsq_datapath.sv =====
module jsq_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  jsq_pkg::cmd_t                cmd,
    input  logic                         cfg_we,
    input  logic [jsq_pkg::CAP_W-1:0]    cfg_capacity,
    input  logic [jsq_pkg::GAP_W-1:0]    job_interval_time,
    input  logic [jsq_pkg::SVC_W-1:0]    job_service_time,
    input  logic                         job_start_run,
    input  logic                         job_first_to_q1,
    output logic [jsq_pkg::PLACE_W-1:0]  placement,
    output logic [jsq_pkg::LEN_W-1:0]    q0_length,
    output logic [jsq_pkg::LEN_W-1:0]    q1_length,
    output logic [jsq_pkg::DROP_W-1:0]   dropped_count,
    output logic [jsq_pkg::WAIT_W-1:0]   wait_total,
    output logic [jsq_pkg::LSUM_W-1:0]   q0_length_sum,
    output logic [jsq_pkg::LSUM_W-1:0]   q1_length_sum
);

    localparam int TW = jsq_pkg::TIME_W;

    // Queue storage: arrival time and service time per entry
    logic [TW-1:0]               arr_mem [2][jsq_pkg::QUEUE_DEPTH];
    logic [jsq_pkg::SVC_W-1:0]   svc_mem [2][jsq_pkg::QUEUE_DEPTH];

    logic [jsq_pkg::CAP_W-1:0]   cap_reg;
    logic [TW-1:0]               now_reg, now_next;
    logic [jsq_pkg::WAIT_W-1:0]  wait_reg, wait_next;
    logic [jsq_pkg::DROP_W-1:0]  drop_reg, drop_next;
    logic [jsq_pkg::PLACE_W-1:0] place_reg, place_next;
    logic [jsq_pkg::CNT_W-1:0]   cnt_reg [2];
    logic [jsq_pkg::CNT_W-1:0]   cnt_next [2];
    logic [jsq_pkg::PTR_W-1:0]   head_reg [2];
    logic [jsq_pkg::PTR_W-1:0]   head_next [2];
    logic [TW-1:0]               free_reg [2];
    logic [TW-1:0]               free_next [2];
    logic [jsq_pkg::LSUM_W-1:0]  lsum_reg [2];
    logic [jsq_pkg::LSUM_W-1:0]  lsum_next [2];
    logic [TW-1:0]               diff_reg [2];
    logic [TW-1:0]               diff_next [2];
    logic [jsq_pkg::SVC_W-1:0]   svcq_reg [2];
    logic [jsq_pkg::SVC_W-1:0]   svcq_next [2];
    logic [TW:0]                 soj_reg [2];
    logic [TW:0]                 soj_next [2];

    logic [TW-1:0]               head_arr [2];
    logic [jsq_pkg::SVC_W-1:0]   head_svc [2];
    logic [jsq_pkg::LSUM_W:0]    lsum_add [2];
    logic [TW:0]                 free_add [2];
    logic [TW:0]                 soj_add [2];
    logic                        hit [2];

    logic [jsq_pkg::CNT_W-1:0]   limit;
    logic [TW:0]                 now_add;
    logic [TW-1:0]               now_sat;
    logic                        sel_q;
    logic                        full;
    logic [TW:0]                 acc_soj;
    logic [jsq_pkg::WAIT_W:0]    wait_add;

    logic                        push_en;
    logic                        push_q;
    logic [TW-1:0]               push_arr;
    logic [jsq_pkg::PTR_W-1:0]   push_idx;

    // Effective limit is the smaller of the register and the queue depth
    assign limit = ({27'd0, cap_reg} > 32'(jsq_pkg::QUEUE_DEPTH))
                 ? jsq_pkg::CNT_W'(jsq_pkg::QUEUE_DEPTH)
                 : jsq_pkg::CNT_W'(cap_reg);

    // Advance the clock, saturating
    assign now_add = {1'b0, now_reg} + (TW+1)'(job_interval_time);
    assign now_sat = now_add[TW] ? '1 : now_add[TW-1:0];

    // Shorter queue wins, ties to queue 0
    assign sel_q = (cnt_reg[0] <= cnt_reg[1]) ? 1'b0 : 1'b1;
    assign full  = (cnt_reg[sel_q] >= limit);

    // One shared adder for both wait-sum steps
    assign acc_soj  = cmd.acc1 ? soj_reg[1] : soj_reg[0];
    assign wait_add = {1'b0, wait_reg} + (jsq_pkg::WAIT_W+1)'(acc_soj);

    always_comb
    begin
        now_next   = now_reg;
        wait_next  = wait_reg;
        drop_next  = drop_reg;
        place_next = place_reg;
        push_en    = 1'b0;
        push_q     = 1'b0;
        push_arr   = now_sat;
        push_idx   = '0;

        for (int q = 0; q < 2; q++)
        begin
            cnt_next[q]  = cnt_reg[q];
            head_next[q] = head_reg[q];
            free_next[q] = free_reg[q];
            lsum_next[q] = lsum_reg[q];
            diff_next[q] = diff_reg[q];
            svcq_next[q] = svcq_reg[q];
            soj_next[q]  = soj_reg[q];
            head_arr[q]  = arr_mem[q][head_reg[q]];
            head_svc[q]  = svc_mem[q][head_reg[q]];
            lsum_add[q]  = {1'b0, lsum_reg[q]} + (jsq_pkg::LSUM_W+1)'(cnt_reg[q]);
            free_add[q]  = {1'b0, now_reg} + (TW+1)'(head_svc[q]);
            soj_add[q]   = {1'b0, diff_reg[q]} + (TW+1)'(svcq_reg[q]);
            hit[q]       = (cnt_reg[q] != '0) && (now_reg >= free_reg[q]);
        end

        // Place the job: a start request clears the run first
        if (cmd.arrive)
        begin
            if (job_start_run)
            begin
                now_next  = '0;
                wait_next = '0;
                drop_next = '0;
                for (int q = 0; q < 2; q++)
                begin
                    cnt_next[q]  = '0;
                    head_next[q] = '0;
                    free_next[q] = '0;
                    lsum_next[q] = '0;
                end
                push_en  = 1'b1;
                push_q   = job_first_to_q1;
                push_arr = '0;
                push_idx = '0;
                cnt_next[job_first_to_q1] = jsq_pkg::CNT_W'(1);
                place_next = job_first_to_q1 ? jsq_pkg::PLACE_Q1 : jsq_pkg::PLACE_Q0;
            end
            else
            begin
                now_next = now_sat;
                for (int q = 0; q < 2; q++)
                begin
                    lsum_next[q] = lsum_add[q][jsq_pkg::LSUM_W]
                                 ? '1 : lsum_add[q][jsq_pkg::LSUM_W-1:0];
                end
                if (full)
                begin
                    drop_next  = (drop_reg == '1) ? drop_reg : drop_reg + 32'd1;
                    place_next = jsq_pkg::PLACE_DROP;
                end
                else
                begin
                    push_en  = 1'b1;
                    push_q   = sel_q;
                    push_idx = head_reg[sel_q] + cnt_reg[sel_q][jsq_pkg::PTR_W-1:0];
                    cnt_next[sel_q] = cnt_reg[sel_q] + jsq_pkg::CNT_W'(1);
                    place_next = sel_q ? jsq_pkg::PLACE_Q1 : jsq_pkg::PLACE_Q0;
                end
            end
        end

        // Serve each open queue head: reopen time, elapsed wait, pop
        if (cmd.serve)
        begin
            for (int q = 0; q < 2; q++)
            begin
                if (hit[q])
                begin
                    free_next[q] = free_add[q][TW] ? '1 : free_add[q][TW-1:0];
                    diff_next[q] = (now_reg > head_arr[q]) ? now_reg - head_arr[q] : '0;
                    svcq_next[q] = head_svc[q];
                    head_next[q] = head_reg[q] + jsq_pkg::PTR_W'(1);
                    cnt_next[q]  = cnt_reg[q] - jsq_pkg::CNT_W'(1);
                end
                else
                begin
                    diff_next[q] = '0;
                    svcq_next[q] = '0;
                end
            end
        end

        // Sojourn is service plus time spent waiting
        if (cmd.sojourn)
        begin
            for (int q = 0; q < 2; q++)
            begin
                soj_next[q] = soj_add[q];
            end
        end

        // Add sojourns to the wait total, saturating
        if (cmd.acc0 || cmd.acc1)
        begin
            wait_next = wait_add[jsq_pkg::WAIT_W] ? '1 : wait_add[jsq_pkg::WAIT_W-1:0];
        end
    end

    // Run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= jsq_pkg::CAP_RESET;
            now_reg  <= '0;
            wait_reg <= '0;
            drop_reg <= '0;
            for (int q = 0; q < 2; q++)
            begin
                cnt_reg[q]  <= '0;
                head_reg[q] <= '0;
                free_reg[q] <= '0;
                lsum_reg[q] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_capacity;
            end
            now_reg  <= now_next;
            wait_reg <= wait_next;
            drop_reg <= drop_next;
            for (int q = 0; q < 2; q++)
            begin
                cnt_reg[q]  <= cnt_next[q];
                head_reg[q] <= head_next[q];
                free_reg[q] <= free_next[q];
                lsum_reg[q] <= lsum_next[q];
            end
        end
    end

    // Per-request working registers
    always_ff @(posedge clk)
    begin
        place_reg <= place_next;
        for (int q = 0; q < 2; q++)
        begin
            diff_reg[q] <= diff_next[q];
            svcq_reg[q] <= svcq_next[q];
            soj_reg[q]  <= soj_next[q];
        end
    end

    // Write the queue tail
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            arr_mem[push_q][push_idx] <= push_arr;
            svc_mem[push_q][push_idx] <= job_service_time;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            placement     <= place_reg;
            q0_length     <= jsq_pkg::LEN_W'(cnt_reg[0]);
            q1_length     <= jsq_pkg::LEN_W'(cnt_reg[1]);
            dropped_count <= drop_reg;
            wait_total    <= wait_reg;
            q0_length_sum <= lsum_reg[0];
            q1_length_sum <= lsum_reg[1];
        end
    end

endmodule
